[hdl/chained_hash_key_value_store_macros.svh]
// Assertion helpers used by the hash store top level.
`ifndef CHAINED_HASH_KEY_VALUE_STORE_MACROS_SVH
`define CHAINED_HASH_KEY_VALUE_STORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CHKV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chkv assertion failed");
`define CHKV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chkv implication failed");
`else
`define CHKV_ASSERT(lbl, prop)
`define CHKV_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[hdl/chkv_pkg.sv]
`default_nettype none
package chkv_pkg;
  localparam int unsigned BUCKETS = 256;
  localparam int unsigned NODES   = 1024;
  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned BC_W    = 9;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned DIV_CYC   = KEY_W / DIV_STEPS;
  localparam int unsigned DCNT_W    = $clog2(DIV_CYC);

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } chkv_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
    logic        full_res;
    logic [10:0] entry_count;
  } chkv_res_t;

  typedef struct packed {
    chkv_item_t       item;
    logic [BKT_W-1:0] bucket;
  } chkv_qent_t;
endpackage
`default_nettype wire

[hdl/chkv_front.sv]
`default_nettype none
module chkv_front import chkv_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire chkv_item_t      in_item_i,
  input  wire logic [BC_W-1:0] eff_buckets_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output chkv_qent_t           q_data_o
);
  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  fstate_e           state_q, state_d;
  chkv_item_t        item_q;
  logic [KEY_W-1:0]  ksh_q, ksh_d;
  logic [BC_W-1:0]   rem_q, rem_d;
  logic [BC_W-1:0]   div_q;
  logic [DCNT_W-1:0] cnt_q, cnt_d;

  // Four restoring remainder steps per cycle, key MSB first.
  always_comb begin
    logic [BC_W:0]    r;
    logic [KEY_W-1:0] k;
    r = {1'b0, rem_q};
    k = ksh_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[BC_W-1:0], k[KEY_W-1]};
      k = {k[KEY_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) r = r - {1'b0, div_q};
    end
    rem_d = r[BC_W-1:0];
    ksh_d = k;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: if (in_valid_i) begin
        state_d = F_DIV;
        cnt_d   = '0;
      end
      F_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_CYC - 1)) state_d = F_PUSH;
      end
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      item_q <= in_item_i;
      ksh_q  <= in_item_i.key;
      rem_q  <= '0;
      div_q  <= eff_buckets_i;
    end else if (state_q == F_DIV) begin
      ksh_q <= ksh_d;
      rem_q <= rem_d;
    end
  end

  assign in_stall_o       = (state_q != F_IDLE);
  assign q_push_o         = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o.item    = item_q;
  assign q_data_o.bucket  = rem_q[BKT_W-1:0];
endmodule
`default_nettype wire

[hdl/chkv_fifo.sv]
`default_nettype none
module chkv_fifo import chkv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire chkv_qent_t data_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output chkv_qent_t      data_o
);
  chkv_qent_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
endmodule
`default_nettype wire

[hdl/chkv_back.sv]
`default_nettype none
module chkv_back import chkv_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire chkv_qent_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output chkv_res_t       out_result_o
);
  typedef enum logic [2:0] {B_IDLE, B_HEAD, B_WALK, B_ALLOC, B_LINK} bstate_e;

  logic [NODE_W-1:0] head_mem [BUCKETS];
  logic [KEY_W-1:0]  key_mem  [NODES];
  logic [31:0]       val_mem  [NODES];
  logic [NODE_W:0]   link_mem [NODES];   // {valid, index}
  logic [BUCKETS-1:0] hv_q;

  bstate_e           state_q, state_d;
  chkv_qent_t        ent_q;
  logic [NODE_W-1:0] head_rd_q, cur_q, cur_d, last_q, last_d;
  logic              have_last_q, have_last_d;
  logic [KEY_W-1:0]  nk_q;
  logic [31:0]       nv_q;
  logic [NODE_W:0]   nl_q;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              out_valid_q, out_valid_d;
  chkv_res_t         res_q, res_d;

  logic pop, taken, emit, decide, hit;
  logic val_we, node_we, link_we, head_we;
  logic [NODE_W-1:0] val_wa, link_wa, new_idx;
  logic [NODE_W:0]   link_wd;

  assign taken   = out_valid_q && !out_stall_i;
  assign pop     = (state_q == B_IDLE) && q_valid_i && (!out_valid_q || taken);
  assign new_idx = used_q[NODE_W-1:0];
  assign hit     = (state_q == B_WALK) && (nk_q == ent_q.item.key);
  assign decide  = (state_q == B_HEAD && !hv_q[ent_q.bucket]) ||
                   (state_q == B_WALK && (hit || !nl_q[NODE_W]));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    last_d      = last_q;
    have_last_d = have_last_q;
    used_d      = used_q;
    emit        = 1'b0;
    res_d       = res_q;
    val_we      = 1'b0;
    val_wa      = cur_q;
    node_we     = 1'b0;
    link_we     = 1'b0;
    link_wa     = new_idx;
    link_wd     = '0;
    head_we     = 1'b0;
    case (state_q)
      B_IDLE: if (pop) state_d = B_HEAD;
      B_HEAD: begin
        have_last_d = 1'b0;
        if (hv_q[ent_q.bucket]) begin
          cur_d   = head_rd_q;
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        // the node just compared becomes the tail candidate
        last_d      = cur_q;
        have_last_d = 1'b1;
        // advance along the chain
        if (!decide) cur_d = nl_q[NODE_W-1:0];
      end
      B_ALLOC: begin
        node_we = 1'b1;
        val_we  = 1'b1;
        val_wa  = new_idx;
        link_we = 1'b1;
        state_d = B_LINK;
      end
      B_LINK: begin
        if (have_last_q) begin
          link_we = 1'b1;
          link_wa = last_q;
          link_wd = {1'b1, new_idx};
        end else begin
          head_we = 1'b1;
        end
        used_d = used_q + 1'b1;
        emit   = 1'b1;
        res_d  = '{found: 1'b0, read_value: '0, full_res: 1'b0, entry_count: used_d};
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase

    if (decide) begin
      res_d = '{found: hit, read_value: '0, full_res: 1'b0, entry_count: used_q};
      if (ent_q.item.func == FUNC_GET) begin
        emit = 1'b1;
        if (hit) res_d.read_value = nv_q;
        state_d = B_IDLE;
      end else if (hit) begin
        emit    = 1'b1;
        val_we  = 1'b1;
        state_d = B_IDLE;
      end else if (used_q >= CNT_W'(NODES)) begin
        emit           = 1'b1;
        res_d.full_res = 1'b1;
        state_d        = B_IDLE;
      end else begin
        state_d = B_ALLOC;
      end
    end

    out_valid_d = emit ? 1'b1 : (taken ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      hv_q        <= '0;
      have_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      have_last_q <= have_last_d;
      if (head_we) hv_q[ent_q.bucket] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) ent_q <= q_data_i;
    cur_q  <= cur_d;
    last_q <= last_d;
    if (emit) res_q <= res_d;
  end

  // Bucket head memory: read at the bucket of the queue head, written when a chain is started.
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[ent_q.bucket] <= new_idx;
    head_rd_q <= head_mem[q_data_i.bucket];
  end

  // Node memories: read follows the next walk pointer.
  always_ff @(posedge clk_i) begin
    if (node_we) key_mem[new_idx] <= ent_q.item.key;
    nk_q <= key_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= ent_q.item.value;
    nv_q <= val_mem[cur_d];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    nl_q <= link_mem[cur_d];
  end

  assign q_pop_o      = pop;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;
endmodule
`default_nettype wire

[hdl/chained_hash_key_value_store.sv]
// Flow: the front computes the bucket remainder, the queue and head lookup follow, then
// the chain is walked node by node; inserts of a new key also pass B_ALLOC and B_LINK.
// The front takes a new word only after pushing the last; the back takes a queue entry
// only when idle and free to emit; the slower side, plus any output stall, sets the rate.
// Reset (rst_ni low, asynchronous): bucket heads empty, node pool empty, bucket_count 256.
// Node memories are not cleared; their contents are used only after being written.
`default_nettype none
`include "chained_hash_key_value_store_macros.svh"
module chained_hash_key_value_store import chkv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire chkv_item_t  in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output chkv_res_t        out_result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [BC_W-1:0] bc_q, eff;
  logic            q_full, q_push, q_pop, q_valid;
  chkv_qent_t      q_in, q_out;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= BC_W'(BUCKETS);
    end else if (psel && penable && pwrite && paddr == ADDR_BUCKET_COUNT) begin
      bc_q <= pwdata[BC_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {{(32-BC_W){1'b0}}, bc_q} : '0;

  // Clamp to 1..BUCKETS.
  always_comb begin
    eff = bc_q;
    if (bc_q == '0) eff = BC_W'(1);
    else if (bc_q > BC_W'(BUCKETS)) eff = BC_W'(BUCKETS);
  end

  chkv_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_item_i,
    .eff_buckets_i(eff),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_in)
  );

  chkv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_out)
  );

  chkv_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_out), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_result_o
  );

  `CHKV_ASSERT(a_no_push_full, !(q_push && q_full))
  `CHKV_ASSERT_IMP(a_count_bound, out_valid_o, out_result_o.entry_count <= CNT_W'(NODES))
  `CHKV_ASSERT_IMP(a_full_pool, out_valid_o && out_result_o.full_res,
                   out_result_o.entry_count == CNT_W'(NODES) && !out_result_o.found)
  `CHKV_ASSERT_IMP(a_value_hit, out_valid_o && out_result_o.read_value != '0,
                   out_result_o.found)
endmodule
`default_nettype wire
